FILE: sv/imk_pkg.sv
// Shared types and constants for the iambic Morse keyer.
`timescale 1ns / 1ps
`default_nettype none
package imk_pkg;

  localparam int TIME_W  = 32;
  localparam int WPM_W   = 11;
  localparam int UNIT_W  = 11;
  localparam int MODE_W  = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;

  // Dit length at one word per minute, in ms
  localparam logic [UNIT_W-1:0] UNITS_PER_MINUTE = 11'd1200;
  localparam int DIV_STEPS = UNIT_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  localparam logic [MODE_W-1:0] MODE_STRAIGHT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_IAMBIC_A = 2'd1;
  localparam logic [MODE_W-1:0] MODE_IAMBIC_B = 2'd2;
  localparam logic [MODE_W-1:0] MODE_RESET    = MODE_IAMBIC_B;

  localparam logic [CFG_IDX_W-1:0] CFG_KEYER_MODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WPM        = 1'd1;

  localparam logic [UNIT_W-1:0] UNIT_RESET = 11'd60;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_DIT  = 2'd1,
    PH_DAH  = 2'd2,
    PH_GAP  = 2'd3
  } phase_t;

endpackage
`default_nettype wire

FILE: sv/imk_in_if.sv
// Paddle sample channel: valid/ready with dit, dah and timestamp.
`timescale 1ns / 1ps
`default_nettype none
interface imk_in_if;
  logic                        valid;
  logic                        ready;
  logic                        dit_paddle;
  logic                        dah_paddle;
  logic [imk_pkg::TIME_W-1:0]  time_ms;

  modport source (output valid, dit_paddle, dah_paddle, time_ms, input ready);
  modport sink   (input valid, dit_paddle, dah_paddle, time_ms, output ready);
endinterface

// Key output channel: valid/ready with the key-down bit.
interface imk_out_if;
  logic valid;
  logic ready;
  logic key_down;

  modport source (output valid, key_down, input ready);
  modport sink   (input valid, key_down, output ready);
endinterface
`default_nettype wire

FILE: sv/iambic_morse_keyer_unit.sv
// Top level of the iambic Morse keyer: paddle sampling, element timing, speed divider.
`timescale 1ns / 1ps
`default_nettype none
// Each sample transfer registers its key_down result in the output register.
// One sample per cycle while out_ch is ready; the output refills in the cycle it is taken.
// A words_per_minute write starts the restoring divider (one quotient bit a cycle);
// in_ch.ready stays low until the new unit length is in place.
// Reset (rst_n low, synchronous): iambic mode B, idle, 20 wpm (unit 60 ms), output empty.
module iambic_morse_keyer_unit (
  input  wire                              clk,
  input  wire                              rst_n,
  imk_in_if.sink                           in_ch,
  imk_out_if.source                        out_ch,
  input  wire                              cfg_wr_en,
  input  wire [imk_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire [imk_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import imk_pkg::*;

  // Configuration and run state
  logic [MODE_W-1:0] mode_r;
  phase_t            phase_r, phase_nxt;
  logic [TIME_W-1:0] elem_end_r, elem_end_nxt;
  logic [TIME_W-1:0] gap_end_r, gap_end_nxt;
  logic              latched_r, latched_nxt;
  logic              extra_r, extra_nxt;
  logic              last_dit_r, last_dit_nxt;
  logic [UNIT_W-1:0] unit_r;

  // Speed divider
  logic                 div_busy_r;
  logic [DIV_CNT_W-1:0] div_cnt_r;
  logic [WPM_W-1:0]     div_den_r;
  logic [UNIT_W-1:0]    div_quo_r;
  logic [WPM_W-1:0]     div_rem_r;
  logic [WPM_W:0]       div_shift;
  logic                 div_ge;
  logic [WPM_W-1:0]     div_rem_nxt;
  logic [WPM_W-1:0]     wpm_eff;

  // Output register
  logic out_valid_r;
  logic key_down_r;
  logic key_nxt;

  logic in_xfer;
  logic mode_wr;
  logic wpm_wr;

  // Per-sample helpers
  logic              opposite;
  logic              same;
  logic              elem_done;
  logic              gap_done;
  logic              begin_el;
  logic              begin_dit;
  logic [UNIT_W+1:0] dah_len;
  logic [UNIT_W+1:0] elem_len;

  // Accept a sample when the output slot is free or drains this cycle,
  // and no speed change is still being worked out.
  assign in_ch.ready  = !div_busy_r && (!out_valid_r || out_ch.ready);
  assign in_xfer      = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.key_down = key_down_r;

  assign mode_wr = cfg_wr_en && (cfg_index == CFG_KEYER_MODE);
  assign wpm_wr  = cfg_wr_en && (cfg_index == CFG_WPM);

  // Zero speed counts as one word per minute
  assign wpm_eff = (cfg_data[WPM_W-1:0] == '0) ? WPM_W'(1) : cfg_data[WPM_W-1:0];

  // One restoring step: shift in the next dividend bit, subtract when it fits
  assign div_shift   = {div_rem_r, div_quo_r[UNIT_W-1]};
  assign div_ge      = div_shift >= {1'b0, div_den_r};
  assign div_rem_nxt = div_ge ? WPM_W'(div_shift - {1'b0, div_den_r})
                              : div_shift[WPM_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_busy_r <= 1'b0;
      div_cnt_r  <= '0;
      unit_r     <= UNIT_RESET;
    end else if (wpm_wr) begin
      // Restart the divider; a fresh write overrides one in flight
      div_busy_r <= 1'b1;
      div_cnt_r  <= DIV_CNT_W'(DIV_STEPS);
      div_den_r  <= wpm_eff;
      div_quo_r  <= UNITS_PER_MINUTE;
      div_rem_r  <= '0;
    end else if (div_busy_r) begin
      div_rem_r <= div_rem_nxt;
      div_quo_r <= {div_quo_r[UNIT_W-2:0], div_ge};
      div_cnt_r <= div_cnt_r - DIV_CNT_W'(1);
      if (div_cnt_r == DIV_CNT_W'(1)) begin
        div_busy_r <= 1'b0;
        // Last quotient bit lands here; clamp a zero unit to one ms
        if ({div_quo_r[UNIT_W-2:0], div_ge} == '0) begin
          unit_r <= UNIT_W'(1);
        end else begin
          unit_r <= {div_quo_r[UNIT_W-2:0], div_ge};
        end
      end
    end
  end

  // Element lengths: a dit is one unit, a dah three
  assign dah_len  = {2'b00, unit_r} + {1'b0, unit_r, 1'b0};
  assign opposite = last_dit_r ? in_ch.dah_paddle : in_ch.dit_paddle;
  assign same     = last_dit_r ? in_ch.dit_paddle : in_ch.dah_paddle;
  assign elem_done = in_ch.time_ms >= elem_end_r;
  assign gap_done  = in_ch.time_ms >= gap_end_r;
  assign elem_len  = begin_dit ? {2'b00, unit_r} : dah_len;

  // Next-state logic for one iambic sample
  always_comb begin
    phase_nxt    = phase_r;
    elem_end_nxt = elem_end_r;
    gap_end_nxt  = gap_end_r;
    latched_nxt  = latched_r;
    extra_nxt    = extra_r;
    last_dit_nxt = last_dit_r;
    begin_el     = 1'b0;
    begin_dit    = 1'b0;
    unique case (phase_r)
      PH_IDLE: begin
        // Dit wins when both paddles are closed
        if (in_ch.dit_paddle) begin
          begin_el  = 1'b1;
          begin_dit = 1'b1;
        end else if (in_ch.dah_paddle) begin
          begin_el  = 1'b1;
          begin_dit = 1'b0;
        end
      end
      PH_DIT, PH_DAH: begin
        if (opposite) begin
          latched_nxt = 1'b1;
        end
        if (elem_done) begin
          phase_nxt   = PH_GAP;
          gap_end_nxt = in_ch.time_ms + TIME_W'(unit_r);
        end
      end
      PH_GAP: begin
        if (opposite) begin
          latched_nxt = 1'b1;
        end
        if (gap_done) begin
          if (opposite) begin
            begin_el  = 1'b1;
            begin_dit = !last_dit_r;
            extra_nxt = 1'b0;
          end else if (same) begin
            begin_el  = 1'b1;
            begin_dit = last_dit_r;
            extra_nxt = 1'b0;
          end else if (mode_r == MODE_IAMBIC_B && latched_r && !extra_r) begin
            // Mode B memory: send the remembered opposite element once
            begin_el  = 1'b1;
            begin_dit = !last_dit_r;
            extra_nxt = 1'b1;
          end else begin
            phase_nxt = PH_IDLE;
            extra_nxt = 1'b0;
          end
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
    if (begin_el) begin
      last_dit_nxt = begin_dit;
      phase_nxt    = begin_dit ? PH_DIT : PH_DAH;
      elem_end_nxt = in_ch.time_ms + TIME_W'(elem_len);
      latched_nxt  = 1'b0;
    end
  end

  // Output logic: straight mode passes the dit contact, else key while sending
  always_comb begin
    if (mode_r == MODE_STRAIGHT) begin
      key_nxt = in_ch.dit_paddle;
    end else begin
      key_nxt = (phase_nxt == PH_DIT) || (phase_nxt == PH_DAH);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_RESET;
      phase_r     <= PH_IDLE;
      elem_end_r  <= '0;
      gap_end_r   <= '0;
      latched_r   <= 1'b0;
      extra_r     <= 1'b0;
      last_dit_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (mode_wr) begin
        // Mode change drops any element in progress
        mode_r     <= cfg_data[MODE_W-1:0];
        phase_r    <= PH_IDLE;
        elem_end_r <= '0;
        gap_end_r  <= '0;
        latched_r  <= 1'b0;
        extra_r    <= 1'b0;
        last_dit_r <= 1'b0;
      end else if (in_xfer && mode_r != MODE_STRAIGHT) begin
        phase_r    <= phase_nxt;
        elem_end_r <= elem_end_nxt;
        gap_end_r  <= gap_end_nxt;
        latched_r  <= latched_nxt;
        extra_r    <= extra_nxt;
        last_dit_r <= last_dit_nxt;
      end
      // Hold the result until taken; refill on each input transfer
      if (in_xfer) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      key_down_r <= key_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: verif/tb_top.sv
// Self-checking testbench for the iambic Morse keyer: paddle sample stream in, key_down out.
`timescale 1ns / 1ps
module tb_top;
  import imk_pkg::*;

  localparam int CLK_PERIOD     = 10;
  localparam int RESET_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 4;

  // Mode code with no name in the package; the keyer treats it as mode A
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

  typedef struct packed {
    logic              dit;
    logic              dah;
    logic [TIME_W-1:0] stamp;
  } paddle_sample_t;

  typedef enum {RX_ALWAYS, RX_PATTERN, RX_RANDOM} rx_style_t;
  typedef enum {G_DIT, G_DAH, G_SQUEEZE, G_DIT_TAP, G_DAH_TAP, G_RELEASE, G_NOISE} gesture_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  imk_in_if  in_if ();
  imk_out_if out_if ();

  iambic_morse_keyer_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Stimulus and bookkeeping
  paddle_sample_t sample_q[$];
  logic           key_down_expected_q[$];
  paddle_sample_t cur_sample;
  logic [TIME_W-1:0] cur_time = '0;
  int unsigned    burst_left = 0;
  int unsigned    gap_left = 0;
  bit             bursty = 1'b0;
  rx_style_t      rx_style = RX_ALWAYS;
  logic [15:0]    stall_pattern = 16'hFFFF;
  logic [31:0]    cyc = '0;
  int unsigned    idle_cycles = 0;
  int unsigned    error_count = 0;
  int unsigned    samples_sent = 0;
  int unsigned    keys_checked = 0;
  int unsigned    settings_run = 0;

  // Keyer state as the predictor sees it
  logic [MODE_W-1:0] kp_mode;
  phase_t            kp_phase;
  logic [TIME_W-1:0] kp_elem_end;
  logic [TIME_W-1:0] kp_gap_end;
  logic              kp_opp_seen;
  logic              kp_memory_sent;
  logic              kp_last_dit;
  logic [UNIT_W-1:0] kp_unit;

  function automatic void keyer_clear();
    kp_phase       = PH_IDLE;
    kp_elem_end    = '0;
    kp_gap_end     = '0;
    kp_opp_seen    = 1'b0;
    kp_memory_sent = 1'b0;
    kp_last_dit    = 1'b0;
  endfunction

  function automatic void keyer_start(input logic dit, input logic [TIME_W-1:0] now);
    logic [TIME_W-1:0] len;
    len = dit ? TIME_W'(kp_unit) : TIME_W'(kp_unit) * 32'd3;
    kp_last_dit = dit;
    kp_phase    = dit ? PH_DIT : PH_DAH;
    kp_elem_end = now + len;
    kp_opp_seen = 1'b0;
  endfunction

  function automatic void keyer_write_reg(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] data);
    int w;
    if (idx == CFG_KEYER_MODE) begin
      kp_mode = data[MODE_W-1:0];
      keyer_clear();
    end else begin
      w = (data == '0) ? 1 : int'(data);
      w = int'(UNITS_PER_MINUTE) / w;
      kp_unit = (w == 0) ? UNIT_W'(1) : UNIT_W'(w);
    end
  endfunction

  // Apply one paddle sample to the predicted state and return the key output
  function automatic logic predict_key_down(input logic dit, input logic dah,
                                            input logic [TIME_W-1:0] now);
    logic opp;
    logic same;
    if (kp_mode == MODE_STRAIGHT) return dit;
    if (kp_phase == PH_IDLE) begin
      // dit wins when both paddles are closed
      if (dit) keyer_start(1'b1, now);
      else if (dah) keyer_start(1'b0, now);
    end else begin
      opp  = kp_last_dit ? dah : dit;
      same = kp_last_dit ? dit : dah;
      if (opp) kp_opp_seen = 1'b1;
      if (kp_phase != PH_GAP) begin
        // plain unsigned compare: no wraparound handling
        if (now >= kp_elem_end) begin
          kp_phase   = PH_GAP;
          kp_gap_end = now + TIME_W'(kp_unit);
        end
      end else if (now >= kp_gap_end) begin
        if (opp) begin
          keyer_start(!kp_last_dit, now);
          kp_memory_sent = 1'b0;
        end else if (same) begin
          keyer_start(kp_last_dit, now);
          kp_memory_sent = 1'b0;
        end else if (kp_mode == MODE_IAMBIC_B && kp_opp_seen && !kp_memory_sent) begin
          keyer_start(!kp_last_dit, now);
          kp_memory_sent = 1'b1;
        end else begin
          kp_phase       = PH_IDLE;
          kp_memory_sent = 1'b0;
        end
      end
    end
    return (kp_phase == PH_DIT) || (kp_phase == PH_DAH);
  endfunction

  // Sender: pop pending samples, in bursts with idle gaps between them in bursty runs.
  // Advance only when the current slot is empty or its transfer happens at this edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid      <= 1'b0;
      in_if.dit_paddle <= 1'b0;
      in_if.dah_paddle <= 1'b0;
      in_if.time_ms    <= '0;
    end else if (!in_if.valid || in_if.ready) begin
      if (gap_left != 0) begin
        gap_left    <= gap_left - 1;
        in_if.valid <= 1'b0;
      end else if (sample_q.size() != 0) begin
        cur_sample = sample_q.pop_front();
        in_if.valid      <= 1'b1;
        in_if.dit_paddle <= cur_sample.dit;
        in_if.dah_paddle <= cur_sample.dah;
        in_if.time_ms    <= cur_sample.stamp;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left   <= bursty ? $urandom_range(0, 7) : 0;
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Receiver: stall on its own schedule, independent of the sender
  always @(posedge clk) begin
    cyc <= cyc + 1;
    case (rx_style)
      RX_ALWAYS:  out_if.ready <= 1'b1;
      RX_PATTERN: out_if.ready <= stall_pattern[cyc[3:0]];
      default:    out_if.ready <= ($urandom_range(0, 99) >= 35);
    endcase
  end

  // Monitor and checker. Register writes update the predictor at the edge they land on;
  // results are checked before this edge's sample is predicted, so a result can never
  // be matched against the sample that is only now being taken.
  always @(posedge clk) begin
    logic expected;
    if (!rst_n) begin
      kp_mode = MODE_RESET;
      keyer_clear();
      kp_unit = UNIT_RESET;
      key_down_expected_q.delete();
    end else begin
      if (cfg_wr_en) keyer_write_reg(cfg_index, cfg_data);
      if (out_if.valid && out_if.ready) begin
        keys_checked++;
        if (key_down_expected_q.size() == 0) begin
          $error("key_down result %0b with no sample pending", out_if.key_down);
          error_count++;
        end else begin
          expected = key_down_expected_q.pop_front();
          if (out_if.key_down !== expected) begin
            $error("key_down mismatch: expected %0b, actual %0b", expected, out_if.key_down);
            error_count++;
          end
        end
      end
      if (in_if.valid && in_if.ready) begin
        samples_sent++;
        key_down_expected_q.push_back(
          predict_key_down(in_if.dit_paddle, in_if.dah_paddle, in_if.time_ms));
      end
    end
  end

  // Watchdog: end the run if nothing moves on either channel for too long
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic push_sample(input logic dit, input logic dah, input logic [TIME_W-1:0] t);
    paddle_sample_t s;
    s.dit   = dit;
    s.dah   = dah;
    s.stamp = t;
    cur_time = t;
    sample_q.push_back(s);
  endtask

  // One paddle gesture, with time steps scaled to the current unit length
  task automatic add_gesture();
    gesture_t    kind;
    int unsigned span;
    int unsigned step_max;
    int unsigned elapsed;
    int unsigned dt;
    logic        d;
    logic        a;
    logic        hold;
    logic        flick;
    logic [TIME_W-1:0] t;
    kind     = gesture_t'($urandom_range(0, G_NOISE));
    span     = kp_unit * $urandom_range(1, 10);
    step_max = kp_unit / 3 + 1;
    elapsed  = 0;
    t        = cur_time;
    while (elapsed < span) begin
      dt    = $urandom_range(0, step_max);
      hold  = (elapsed < span / 2);
      flick = (elapsed >= span / 4) && (elapsed < span / 4 + step_max);
      case (kind)
        G_DIT:     begin d = 1'b1; a = 1'b0; end
        G_DAH:     begin d = 1'b0; a = 1'b1; end
        G_SQUEEZE: begin d = 1'b1; a = 1'b1; end
        // hold one paddle, flick the other once, then let go of both
        G_DIT_TAP: begin d = hold;  a = flick; end
        G_DAH_TAP: begin d = flick; a = hold;  end
        G_RELEASE: begin d = 1'b0; a = 1'b0; end
        default: begin
          {d, a} = 2'($urandom);
          if ($urandom_range(0, 39) == 0) t = $urandom;
          else if ($urandom_range(0, 3) == 0) t = t - $urandom_range(0, 2 * kp_unit);
        end
      endcase
      t = t + dt;
      elapsed += dt + 1;
      push_sample(d, a, t);
    end
  endtask

  // Hold until every queued sample has gone and every result has come back
  task automatic drain();
    do @(negedge clk);
    while (sample_q.size() != 0 || in_if.valid || key_down_expected_q.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic run_phase(input bit wr_mode, input logic [MODE_W-1:0] mode,
                           input int unsigned wpm, input int unsigned n_items);
    logic [CFG_DATA_W-1:0] mode_word;
    drain();
    mode_word = CFG_DATA_W'($urandom);
    mode_word[MODE_W-1:0] = mode;
    if (wr_mode) write_reg(CFG_KEYER_MODE, mode_word);
    write_reg(CFG_WPM, CFG_DATA_W'(wpm));
    // the speed divider holds off samples until the new unit is in place
    do @(negedge clk);
    while (!in_if.ready);
    settings_run++;
    bursty        = $urandom_range(0, 1);
    rx_style      = rx_style_t'($urandom_range(0, 2));
    stall_pattern = 16'($urandom) | 16'h0001;
    while (sample_q.size() < n_items) add_gesture();
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part at reset settings (mode B, 20 wpm, 60 ms unit)
    push_sample(1'b0, 1'b0, 32'd0);
    push_sample(1'b1, 1'b1, 32'd0);          // both closed in idle: dit first
    push_sample(1'b0, 1'b0, 32'd30);
    push_sample(1'b0, 1'b1, 32'd60);         // dah tap during the dit is remembered
    push_sample(1'b0, 1'b0, 32'd120);        // memory dah goes out once
    push_sample(1'b0, 1'b0, 32'd300);
    push_sample(1'b0, 1'b0, 32'd360);
    push_sample(1'b0, 1'b1, 32'd400);        // held dah repeats
    push_sample(1'b0, 1'b1, 32'd580);
    push_sample(1'b0, 1'b1, 32'd640);
    push_sample(1'b1, 1'b1, 32'd820);        // squeeze alternates
    push_sample(1'b1, 1'b1, 32'd880);
    push_sample(1'b1, 1'b1, 32'd1000);
    push_sample(1'b0, 1'b0, 32'd1100);
    push_sample(1'b0, 1'b0, 32'd1200);
    push_sample(1'b0, 1'b0, 32'd1500);
    push_sample(1'b0, 1'b0, 32'd1600);
    push_sample(1'b1, 1'b0, 32'hFFFF_FFF0);  // element end wraps past zero
    push_sample(1'b1, 1'b0, 32'hFFFF_FFF8);
    push_sample(1'b0, 1'b0, 32'hFFFF_FFFF);
    push_sample(1'b1, 1'b1, 32'd5);          // time goes backwards
    push_sample(1'b0, 1'b0, 32'd2);
    push_sample(1'b0, 1'b1, 32'hFFFF_FFFF);
    push_sample(1'b1, 1'b0, 32'd0);
    settings_run++;

    // Random part across modes and speeds, extremes included
    run_phase(1'b1, MODE_STRAIGHT, 20,   40);
    run_phase(1'b1, MODE_IAMBIC_A, 20,   60);
    run_phase(1'b1, MODE_IAMBIC_B, 2047, 50);   // unit floors at 1 ms
    run_phase(1'b1, MODE_SPARE,    0,    40);   // wpm 0 taken as 1: 1200 ms unit
    run_phase(1'b1, MODE_IAMBIC_B, 13,   60);
    run_phase(1'b0, MODE_IAMBIC_B, 40,   40);   // speed change with the keyer mid-run
    run_phase(1'b1, MODE_IAMBIC_A, 1201, 40);
    run_phase(1'b1, MODE_IAMBIC_B, $urandom_range(5, 60), 60);
    run_phase(1'b1, MODE_STRAIGHT, $urandom_range(0, 2047), 30);
    run_phase(1'b1, MODE_IAMBIC_B, 25,   60);
    run_phase(1'b1, MODE_IAMBIC_A, 1,    40);

    drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (key_down_expected_q.size() != 0) begin
      $error("key_down: %0d results never arrived", key_down_expected_q.size());
      error_count++;
    end
    $display("Sent %0d paddle samples and checked %0d key_down results over %0d settings",
             samples_sent, keys_checked, settings_run);
    $display("Covered straight, mode A, mode B and the spare mode code, 0 to 2047 wpm");
    if (error_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
